// ===== hdl/kthe_pkg.sv =====
// kthe_pkg: shared widths, reset constants and cell link types
// for the k-th largest threshold estimator; no dependencies
package kthe_pkg;

  localparam int unsigned ScoreW = 10;
  localparam int unsigned RankW = 5;
  localparam logic [RankW-1:0] RankReset = RankW'(10);

  typedef logic [ScoreW-1:0] score_t;
  typedef logic [RankW-1:0] rank_t;

  // what one cell shows its right-hand neighbour
  typedef struct packed {
    logic   keep;
    logic   occ;
    score_t val;
  } cell_link_t;

  // per-word control broadcast to every cell
  typedef struct packed {
    logic   ins;
    logic   clr;
    score_t score;
  } cell_ctrl_t;

endpackage

// ===== hdl/kthe_cell.sv =====
// kthe_cell: one slot of the sorted score row, compare-and-shift insertion
// depends on kthe_pkg
module kthe_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  kthe_pkg::cell_ctrl_t ctrl_i,
  input  kthe_pkg::cell_link_t prev_i,
  output kthe_pkg::cell_link_t link_o,
  output logic               nxt_occ_o,
  output kthe_pkg::score_t   nxt_val_o
);
  import kthe_pkg::*;

  logic   occ_q;
  logic   occ_d;
  score_t val_q;
  score_t val_d;
  logic   own_keep;

  assign own_keep = occ_q && (val_q >= ctrl_i.score);

  always_comb begin
    nxt_occ_o = occ_q;
    nxt_val_o = val_q;
    if (ctrl_i.ins && !own_keep) begin
      if (prev_i.keep) begin
        nxt_occ_o = 1'b1;
        nxt_val_o = ctrl_i.score;
      end else begin
        nxt_occ_o = prev_i.occ;
        nxt_val_o = prev_i.val;
      end
    end
  end

  assign occ_d = ctrl_i.clr ? 1'b0 : nxt_occ_o;
  assign val_d = nxt_val_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign link_o.keep = own_keep;
  assign link_o.occ  = occ_q;
  assign link_o.val  = val_q;

endmodule

// ===== hdl/kthe_out_buf.sv =====
// kthe_out_buf: output register with one skid slot for threshold words
// depends on kthe_pkg
module kthe_out_buf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  kthe_pkg::score_t data_i,
  output logic             full_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output kthe_pkg::score_t data_o
);
  import kthe_pkg::*;

  logic   out_valid_q;
  logic   out_valid_d;
  score_t out_q;
  score_t out_d;
  logic   skid_valid_q;
  logic   skid_valid_d;
  score_t skid_q;
  score_t skid_d;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (!out_valid_q) begin
      out_valid_d = push_i;
      out_d       = data_i;
    end else if (out_ready_i) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = push_i;
        out_d       = data_i;
      end
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_d       = data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign data_o      = out_q;

endmodule

// ===== hdl/kth_largest_threshold_estimator_top.sv =====
// kth_largest_threshold_estimator_top: top level, row of sorting cells,
// rank select, running threshold and output buffer
// depends on kthe_pkg, kthe_cell, kthe_out_buf

// Takes one score word per clock, every clock, as long as the output side
// keeps up: in_ready_o only drops when two threshold words wait unread.
// Scores are held in a row of K_MAX cells sorted largest first; a new score
// is compared against every cell at once and the smaller entries shift one
// cell along, so insertion, list close and threshold update all finish in
// the cycle the word is accepted. An end_of_query word pushes its threshold
// into the registered output buffer, behind earlier unread thresholds.
// The user must write k_rank through the cfg port while the block is idle;
// the block does not enforce this. cfg_ready_o is always high.
module kth_largest_threshold_estimator_top #(
  parameter int unsigned K_MAX = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  kthe_pkg::rank_t     k_rank_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  kthe_pkg::score_t    score_i,
  input  logic                score_valid_i,
  input  logic                end_of_term_i,
  input  logic                end_of_query_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output kthe_pkg::score_t    threshold_o
);
  import kthe_pkg::*;

  localparam int unsigned IdxW = $clog2(K_MAX + 1);
  localparam int unsigned CmpW = (IdxW > RankW) ? IdxW : RankW;

  rank_t      k_rank_q;
  score_t     thr_q;
  score_t     thr_d;
  logic       accept;
  logic       close_list;
  logic       buf_full;
  cell_ctrl_t ctrl;
  cell_link_t links [K_MAX+1];
  logic   [K_MAX-1:0] nxt_occ;
  score_t             nxt_val [K_MAX];
  logic   [K_MAX-1:0] occ_vec;
  logic   [K_MAX-1:0] hit_vec;
  score_t cand;
  score_t thr_new;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_rank_q <= RankReset;
    end else if (cfg_valid_i) begin
      k_rank_q <= k_rank_i;
    end
  end

  assign in_ready_o = !buf_full;
  assign accept     = in_valid_i && in_ready_o;
  assign close_list = end_of_term_i || end_of_query_i;

  assign ctrl.ins   = accept && score_valid_i;
  assign ctrl.clr   = accept && close_list;
  assign ctrl.score = score_i;

  assign links[0].keep = 1'b1;
  assign links[0].occ  = 1'b0;
  assign links[0].val  = '0;

  for (genvar i = 0; i < K_MAX; i++) begin : g_cell
    kthe_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .prev_i    (links[i]),
      .link_o    (links[i+1]),
      .nxt_occ_o (nxt_occ[i]),
      .nxt_val_o (nxt_val[i])
    );
    assign occ_vec[i] = links[i+1].occ;
    assign hit_vec[i] = nxt_occ[i]
                        && (CmpW'(k_rank_q) == CmpW'(i + 1));
  end

  // at most one cell matches the rank
  always_comb begin
    cand = '0;
    for (int unsigned i = 0; i < K_MAX; i++) begin
      cand = cand | (nxt_val[i] & {ScoreW{hit_vec[i]}});
    end
  end

  assign thr_new = ((|hit_vec) && (cand > thr_q)) ? cand : thr_q;

  always_comb begin
    thr_d = thr_q;
    if (accept && end_of_query_i) begin
      thr_d = '0;
    end else if (accept && close_list) begin
      thr_d = thr_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else begin
      thr_q <= thr_d;
    end
  end

  kthe_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept && end_of_query_i),
    .data_i      (thr_new),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .data_o      (threshold_o)
  );

`ifndef SYNTH
  a_occ_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((occ_vec + K_MAX'(1)) & occ_vec) == '0)
    else $error("occupied cells not packed from the head");

  a_clear_on_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && close_list) |=> (occ_vec == '0))
    else $error("cells not cleared after list close");

  a_query_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && end_of_query_i) |=> out_valid_o)
    else $error("end of query produced no threshold word");

  a_thr_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && end_of_query_i) |=> (thr_q == '0))
    else $error("threshold not cleared after end of query");
`endif

endmodule

// ===== tb/tb_kth_largest_threshold_estimator_top.sv =====
`timescale 1ns / 100ps
// tb_kth_largest_threshold_estimator_top: self-checking bench for the k-th largest
// threshold estimator, with queue-fed driver, own threshold predictor and checker
// depends on kthe_pkg and kth_largest_threshold_estimator_top
module tb_kth_largest_threshold_estimator_top;
  import kthe_pkg::*;

  localparam int unsigned Depth = 16;
  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned MaxList = 40;
  localparam score_t ScoreTop = '1;

  typedef struct {
    score_t score;
    logic   sv;
    logic   eot;
    logic   eoq;
  } score_word_t;

  typedef enum int unsigned {
    SpreadWide,
    SpreadNarrow,
    SpreadEdges,
    SpreadRising
  } spread_e;

  logic   clk_i = 1'b0;
  logic   rst_ni = 1'b0;
  logic   cfg_valid_i = 1'b0;
  logic   cfg_ready_o;
  rank_t  k_rank_i = '0;
  logic   in_valid_i = 1'b0;
  logic   in_ready_o;
  score_t score_i = '0;
  logic   score_valid_i = 1'b0;
  logic   end_of_term_i = 1'b0;
  logic   end_of_query_i = 1'b0;
  logic   out_valid_o;
  logic   out_ready_i = 1'b0;
  score_t threshold_o;

  kth_largest_threshold_estimator_top #(
    .K_MAX(Depth)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .k_rank_i      (k_rank_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .score_i       (score_i),
    .score_valid_i (score_valid_i),
    .end_of_term_i (end_of_term_i),
    .end_of_query_i(end_of_query_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .threshold_o   (threshold_o)
  );

  // model state
  score_t      held_scores [Depth];
  int unsigned held_count = 0;
  score_t      query_thr = '0;
  rank_t       rank_model = RankReset;

  score_word_t word_q[$];
  score_t      thr_q[$];
  int unsigned n_errors = 0;
  int unsigned n_words = 0;
  int unsigned cycles = 0;
  int unsigned in_gap = 0;
  int unsigned out_stall = 0;
  bit          in_quiet = 1'b0;
  bit          out_quiet = 1'b0;
  score_word_t drv_word;
  score_t      thr_expected;

  always #4 clk_i = ~clk_i;

  // sorted insertion, list close on term or query end, threshold word on query end
  function automatic void predict_threshold(score_t s, logic sv, logic eot, logic eoq);
    int unsigned pos;
    int unsigned i;
    score_t cand;
    if (sv) begin
      pos = 0;
      while (pos < held_count && held_scores[pos] >= s) pos++;
      if (pos < Depth) begin
        i = (held_count < Depth) ? held_count : Depth - 1;
        while (i > pos) begin
          held_scores[i] = held_scores[i-1];
          i--;
        end
        held_scores[pos] = s;
        if (held_count < Depth) held_count++;
      end
    end
    if (eot || eoq) begin
      if (rank_model >= 1 && rank_model <= Depth && held_count >= rank_model) begin
        cand = held_scores[rank_model-1];
        if (cand > query_thr) query_thr = cand;
      end
      held_count = 0;
    end
    if (eoq) begin
      thr_q.insert(thr_q.size(), query_thr);
      query_thr = '0;
    end
  endfunction

  function automatic int unsigned gap_len(bit quiet);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic score_t pick_score(spread_e sp, int unsigned idx);
    case (sp)
      SpreadNarrow: pick_score = score_t'(500 + $urandom_range(0, 3));
      SpreadEdges:  pick_score = $urandom_range(0, 1) ? ScoreTop : '0;
      SpreadRising: pick_score = score_t'(idx * 25 + $urandom_range(0, 20));
      default:      pick_score = score_t'($urandom_range(0, 1023));
    endcase
  endfunction

  task automatic push_word(input score_t s, input logic sv, input logic eot, input logic eoq);
    score_word_t w;
    w.score = s;
    w.sv = sv;
    w.eot = eot;
    w.eoq = eoq;
    word_q.insert(word_q.size(), w);
    if (sv || eot || eoq) n_words++;
  endtask

  task automatic push_term(input bit last);
    int unsigned len;
    int unsigned r;
    int unsigned i;
    spread_e sp;
    bit split;
    bit eot_mark;
    bit fin;
    r = $urandom_range(0, 99);
    if (r < 10) len = 0;
    else if (r < 65) len = $urandom_range(1, Depth);
    else if (r < 85) len = $urandom_range(Depth + 1, MaxList);
    else begin
      // lengths around the rank
      len = rank_model + $urandom_range(0, 2);
      len = (len == 0) ? 0 : len - 1;
      if (len > MaxList) len = MaxList;
    end
    sp = spread_e'($urandom_range(0, 3));
    split = (len == 0) || ($urandom_range(0, 3) == 0);
    eot_mark = !last || ($urandom_range(0, 2) != 0);
    for (i = 0; i < len; i++) begin
      if ($urandom_range(0, 19) == 0) push_word(score_t'($urandom), 1'b0, 1'b0, 1'b0);
      fin = !split && (i == len - 1);
      push_word(pick_score(sp, i), 1'b1, fin && eot_mark, fin && last);
    end
    if (split) push_word(score_t'($urandom), 1'b0, eot_mark, last);
  endtask

  task automatic push_query();
    int unsigned n_terms;
    int unsigned t;
    int unsigned n_junk;
    if ($urandom_range(0, 9) == 0) begin
      // broken sequence of arbitrary markers
      n_junk = $urandom_range(1, 12);
      for (t = 0; t < n_junk; t++)
        push_word(score_t'($urandom), 1'($urandom_range(0, 1)), $urandom_range(0, 4) == 0,
                  $urandom_range(0, 7) == 0);
    end
    n_terms = $urandom_range(1, 4);
    for (t = 0; t < n_terms; t++) push_term(t == n_terms - 1);
  endtask

  task automatic wait_idle();
    while (word_q.size() != 0 || in_valid_i || thr_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_rank(input rank_t r);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    k_rank_i <= r;
    do @(posedge clk_i); while (!cfg_ready_o);
    rank_model = r;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_phase(input rank_t r, input int unsigned target);
    write_rank(r);
    in_quiet = ($urandom_range(0, 3) == 0);
    out_quiet = ($urandom_range(0, 3) == 0);
    n_words = 0;
    while (n_words < target) push_query();
    wait_idle();
  endtask

  // input driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o)
        predict_threshold(score_i, score_valid_i, end_of_term_i, end_of_query_i);
      if (!in_valid_i || in_ready_o) begin
        if (in_gap != 0) begin
          in_valid_i <= 1'b0;
          in_gap--;
        end else if (word_q.size() != 0) begin
          drv_word = word_q.pop_front();
          score_i <= drv_word.score;
          score_valid_i <= drv_word.sv;
          end_of_term_i <= drv_word.eot;
          end_of_query_i <= drv_word.eoq;
          in_valid_i <= 1'b1;
          in_gap = gap_len(in_quiet);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // output monitor and checker
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (thr_q.size() == 0) begin
          n_errors++;
          if (n_errors < 40)
            $display("%0t: threshold word %0d with none expected", $time, threshold_o);
        end else begin
          thr_expected = thr_q.pop_front();
          if (threshold_o !== thr_expected) begin
            n_errors++;
            if (n_errors < 40)
              $display("%0t: threshold expected %0d actual %0d", $time, thr_expected,
                       threshold_o);
          end
        end
      end
      if (out_stall != 0) begin
        out_ready_i <= 1'b0;
        out_stall--;
      end else begin
        out_ready_i <= 1'b1;
        out_stall = gap_len(out_quiet);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb_kth_largest_threshold_estimator_top NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset rank of ten: extremes, duplicates, end of query closing the term
    push_word(10'd1023, 1'b1, 1'b0, 1'b0);
    push_word(10'd3, 1'b1, 1'b0, 1'b0);
    push_word(10'd512, 1'b1, 1'b0, 1'b0);
    repeat (6) push_word(10'd5, 1'b1, 1'b0, 1'b0);
    push_word(10'd7, 1'b1, 1'b0, 1'b1);
    // empty list, then an empty query
    push_word(ScoreTop, 1'b0, 1'b1, 1'b0);
    push_word(ScoreTop, 1'b0, 1'b0, 1'b1);
    // list shorter than the rank
    repeat (8) push_word(ScoreTop, 1'b1, 1'b0, 1'b0);
    push_word(10'd0, 1'b1, 1'b1, 1'b1);
    // ignored word, then a single-score query
    push_word(ScoreTop, 1'b0, 1'b0, 1'b0);
    push_word(ScoreTop, 1'b1, 1'b1, 1'b1);
    wait_idle();

    run_phase(rank_t'(1), 155);
    run_phase(rank_t'(Depth), 155);
    run_phase(rank_t'(0), 100);
    run_phase(rank_t'(31), 100);
    run_phase(rank_t'(Depth + 1), 100);
    run_phase(rank_t'(2), 155);
    run_phase(rank_t'($urandom_range(1, Depth)), 155);
    run_phase(rank_t'($urandom_range(1, Depth)), 155);
    run_phase(rank_t'($urandom_range(1, Depth)), 155);
    run_phase(rank_t'(Depth - 1), 155);
    run_phase(RankReset, 155);

    repeat (8) @(posedge clk_i);
    if (n_errors == 0 && thr_q.size() == 0) begin
      $display("tb_kth_largest_threshold_estimator_top OK");
    end else begin
      $display("tb_kth_largest_threshold_estimator_top NOT OK");
    end
    $finish;
  end

endmodule
